// ----- src/sha256_byte_stream_hasher_assert.svh -----
// ---------------------------------------------------------------------------
// SHA-256 byte stream hasher: assertion macros
// Shorthand for clocked assertions; clk and rst come from the using scope.
// ---------------------------------------------------------------------------
`ifndef SHA256_BYTE_STREAM_HASHER_ASSERT_SVH
`define SHA256_BYTE_STREAM_HASHER_ASSERT_SVH

// Same-cycle implication, disabled in reset
`define SBH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset
`define SBH_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/sbh_pkg.sv -----
// ---------------------------------------------------------------------------
// SHA-256 byte stream hasher package
// Field widths, round constants, initial hash values and sigma functions.
// ---------------------------------------------------------------------------
package sbh_pkg;

  localparam int DATA_W   = 8;
  localparam int DIGEST_W = 64;

  // Padding marker byte and byte position where the bit length starts
  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;
  localparam logic [5:0] LAST_POS = 6'd63;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [0:7][31:0] H_INIT = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

// ----- src/sbh_if.sv -----
// ---------------------------------------------------------------------------
// SHA-256 byte stream hasher channels
// Valid/ready channels for message bytes and for digests.
// ---------------------------------------------------------------------------
interface sbh_in_if import sbh_pkg::*;;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;
  logic              byte_present;
  logic              last_item;

  modport source (output valid, data_byte, byte_present, last_item, input ready);
  modport sink (input valid, data_byte, byte_present, last_item, output ready);
endinterface

interface sbh_out_if import sbh_pkg::*;;
  logic                valid;
  logic                ready;
  logic [DIGEST_W-1:0] digest_high;
  logic [DIGEST_W-1:0] digest_upper_mid;
  logic [DIGEST_W-1:0] digest_lower_mid;
  logic [DIGEST_W-1:0] digest_low;

  modport source (output valid, digest_high, digest_upper_mid, digest_lower_mid,
                  digest_low, input ready);
  modport sink (input valid, digest_high, digest_upper_mid, digest_lower_mid,
                digest_low, output ready);
endinterface

// ----- src/sha256_byte_stream_hasher.sv -----
// ---------------------------------------------------------------------------
// SHA-256 byte stream hasher
// Byte-wide SHA-256 with in-line padding and a registered digest output.
// ---------------------------------------------------------------------------
// Input bytes are taken only in the idle state; every 64th byte starts a
// compression of 64 rounds on the single round unit plus one hash update,
// during which no further bytes are accepted. A transfer with last_item set
// starts padding: one pad byte per cycle up to byte 56 of the block, then
// the bit length, and one or two compressions before the digest is loaded
// into the output register. The output register holds a digest until it is
// taken while the next message is already being accepted; a second digest
// waits in the finish state until the first one has been transferred.
module sha256_byte_stream_hasher
  import sbh_pkg::*;
(
  input logic       clk,
  input logic       rst,
  sbh_in_if.sink    msg,
  sbh_out_if.source digest
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_PAD   = 5'b00010,
    ST_ROUND = 5'b00100,
    ST_HADD  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t          state;
  logic [5:0]      fill;        // bytes in the current block
  logic [5:0]      round;
  logic [63:0]     bitlen;
  logic            pad_marked;  // 0x80 marker already shifted in
  logic            finishing;   // message end seen, padding in progress
  logic            final_blk;   // block being compressed carries the length
  logic [0:7][31:0] hash;
  logic [0:7][31:0] work;
  // 16-word message window, oldest word in the top bits
  logic [511:0]    sched;

  // Round datapath
  logic [31:0] w_cur, w_new, t1, t2, ch, maj;
  logic [7:0]  pad_byte;

  assign w_cur = sched[511:480];
  assign w_new = small_sigma1(sched[63:32]) + sched[223:192]
               + small_sigma0(sched[479:448]) + w_cur;
  assign ch    = (work[4] & work[5]) ^ (~work[4] & work[6]);
  assign maj   = (work[0] & work[1]) ^ (work[0] & work[2]) ^ (work[1] & work[2]);
  assign t1    = work[7] + big_sigma1(work[4]) + ch + ROUND_K[round] + w_cur;
  assign t2    = big_sigma0(work[0]) + maj;

  assign pad_byte = pad_marked ? 8'h00 : PAD_MARK;

  assign msg.ready = (state == ST_IDLE);

  // Sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      fill         <= '0;
      round        <= '0;
      bitlen       <= '0;
      pad_marked   <= 1'b0;
      finishing    <= 1'b0;
      final_blk    <= 1'b0;
      hash         <= H_INIT;
      digest.valid <= 1'b0;
    end else begin
      // Finish state reloads the output register itself
      if (digest.valid && digest.ready && state != ST_DONE) begin
        digest.valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (msg.valid) begin
            finishing <= msg.last_item;
            if (msg.byte_present) begin
              sched  <= {sched[503:0], msg.data_byte};
              bitlen <= bitlen + 64'd8;
              fill   <= fill + 6'd1;
            end
            if (msg.byte_present && fill == LAST_POS) begin
              work  <= hash;
              round <= '0;
              state <= ST_ROUND;
            end else if (msg.last_item) begin
              state <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          if (pad_marked && fill == LEN_POS) begin
            // length closes the block
            sched     <= {sched[447:0], bitlen};
            fill      <= '0;
            final_blk <= 1'b1;
            work      <= hash;
            round     <= '0;
            state     <= ST_ROUND;
          end else begin
            sched      <= {sched[503:0], pad_byte};
            pad_marked <= 1'b1;
            fill       <= fill + 6'd1;
            if (fill == LAST_POS) begin
              work  <= hash;
              round <= '0;
              state <= ST_ROUND;
            end
          end
        end
        ST_ROUND: begin
          work  <= {t1 + t2, work[0], work[1], work[2],
                    work[3] + t1, work[4], work[5], work[6]};
          sched <= {sched[479:0], w_new};
          round <= round + 6'd1;
          if (round == LAST_POS) begin
            state <= ST_HADD;
          end
        end
        ST_HADD: begin
          for (int i = 0; i < 8; i++) begin
            hash[i] <= hash[i] + work[i];
          end
          priority if (final_blk) begin
            state <= ST_DONE;
          end else if (finishing) begin
            state <= ST_PAD;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_DONE: begin
          if (!digest.valid || digest.ready) begin
            digest.valid            <= 1'b1;
            digest.digest_high      <= {hash[0], hash[1]};
            digest.digest_upper_mid <= {hash[2], hash[3]};
            digest.digest_lower_mid <= {hash[4], hash[5]};
            digest.digest_low       <= {hash[6], hash[7]};
            hash       <= H_INIT;
            bitlen     <= '0;
            fill       <= '0;
            pad_marked <= 1'b0;
            finishing  <= 1'b0;
            final_blk  <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- src/sbh_checker.sv -----
// ---------------------------------------------------------------------------
// SHA-256 byte stream hasher port checker
// Watches the top-level channels and flags handshake and sequencing slips.
// ---------------------------------------------------------------------------
`include "sha256_byte_stream_hasher_assert.svh"

module sbh_checker
  import sbh_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                in_last,
  input logic                out_valid,
  input logic                out_ready,
  input logic [DIGEST_W-1:0] out_high
);

  // Digest output holds while stalled
  `SBH_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "digest dropped while stalled")
  `SBH_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable(out_high), "digest changed while stalled")

  // A message end always leaves the idle state, so input stalls next cycle
  `SBH_ASSERT_NXT(a_end_stalls, in_valid && in_ready && in_last, !in_ready, "input open after message end")

  // A new digest appears only out of the finish step, never while bytes are taken
  `SBH_ASSERT_IMP(a_digest_src, $rose(out_valid), !$past(in_ready), "digest loaded while accepting input")

endmodule

bind sha256_byte_stream_hasher sbh_checker u_sbh_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (msg.valid),
  .in_ready  (msg.ready),
  .in_last   (msg.last_item),
  .out_valid (digest.valid),
  .out_ready (digest.ready),
  .out_high  (digest.digest_high)
);

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SHA-256 byte stream hasher testbench
// Streams directed and random messages through the byte channel, computes
// each digest with an in-bench SHA-256 and checks every digest transfer
// against the oldest pending value. Both channels idle in random bursts, and
// the digest side holds off once for a long stretch so the input backs up.
// ---------------------------------------------------------------------------
module tb
  import sbh_pkg::*;
;

  localparam int RANDOM_ITEMS = 1700;
  localparam int CALM_ITEMS   = 150;
  localparam int LONG_HOLD    = 2500;
  localparam int DRAIN_CYCLES = 300;
  localparam int LIMIT_CYCLES = 2000000;
  localparam int DIR_ROWS     = 22;

  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam int         LEN_OFFSET = 56;

  typedef struct packed {
    logic [DIGEST_W-1:0] high;
    logic [DIGEST_W-1:0] upper_mid;
    logic [DIGEST_W-1:0] lower_mid;
    logic [DIGEST_W-1:0] low;
  } digest_t;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic              present;
    logic              last;
    logic              known;
    digest_t           want;
  } dir_row_t;

  localparam digest_t EMPTY_DIGEST = {64'he3b0c44298fc1c14, 64'h9afbf4c8996fb924,
                                      64'h27ae41e4649b934c, 64'ha495991b7852b855};
  localparam digest_t ABC_DIGEST   = {64'hba7816bf8f01cfea, 64'h414140de5dae2223,
                                      64'hb00361a396177a9c, 64'hb410ff61f20015ad};

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Message lengths around the padding and block boundaries
  localparam int EDGE_LENS [13] = '{0, 1, 55, 56, 57, 63, 64, 65, 119, 120, 121, 127, 128};

  // Directed messages: empty, "abc" ended both ways, extreme byte values
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},  // empty message right after reset
    '{8'ha5, 1'b0, 1'b0, 1'b0, '0},            // empty items change nothing
    '{8'h5a, 1'b0, 1'b0, 1'b0, '0},
    '{8'hff, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},  // byte ignored when not present
    '{8'h61, 1'b1, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, 1'b0, '0},            // empty item inside a message
    '{8'h62, 1'b1, 1'b0, 1'b0, '0},
    '{8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST},    // byte and end in one item
    '{8'h61, 1'b1, 1'b0, 1'b0, '0},
    '{8'h62, 1'b1, 1'b0, 1'b0, '0},
    '{8'h63, 1'b1, 1'b0, 1'b0, '0},
    '{8'h3c, 1'b0, 1'b1, 1'b1, ABC_DIGEST},    // end on an empty item
    '{8'h00, 1'b1, 1'b1, 1'b0, '0},
    '{8'hff, 1'b1, 1'b1, 1'b0, '0},
    '{8'hff, 1'b1, 1'b0, 1'b0, '0},
    '{8'h00, 1'b1, 1'b0, 1'b0, '0},
    '{8'h80, 1'b1, 1'b0, 1'b0, '0},
    '{8'h7f, 1'b1, 1'b0, 1'b0, '0},
    '{8'h01, 1'b1, 1'b0, 1'b0, '0},
    '{8'hfe, 1'b1, 1'b1, 1'b0, '0},
    '{8'h55, 1'b0, 1'b0, 1'b0, '0},
    '{8'haa, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST}
  };

  logic clk;
  logic rst;

  sbh_in_if  msg_ch ();
  sbh_out_if dig_ch ();

  sha256_byte_stream_hasher u_dut (
    .clk    (clk),
    .rst    (rst),
    .msg    (msg_ch.sink),
    .digest (dig_ch.source)
  );

  // Hash state of the in-bench SHA-256
  logic [7:0]  msg_block [64];
  int          block_fill;
  logic [63:0] msg_bits;
  logic [31:0] hash_state [8];

  digest_t pending_digests [$];
  int      errors;
  int      items_sent;
  int      digests_seen;
  int      cycle_count;
  int      src_idle_pct;
  int      snk_idle_pct;
  int      sink_hold;
  bit      long_hold_done;
  bit      calm;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void hash_restart();
    for (int i = 0; i < 8; i++) hash_state[i] = SHA_IV[i];
    block_fill = 0;
    msg_bits   = '0;
  endfunction

  // One 64-round compression of msg_block into hash_state
  function automatic void hash_compress();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
    for (int t = 0; t < 16; t++)
      w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
    for (int t = 16; t < 64; t++)
      w[t] = (rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7] +
             (rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
    a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
    e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
    for (int t = 0; t < 64; t++) begin
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g)) +
           SHA_K[t] + w[t];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
    hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
  endfunction

  // Absorb one byte transfer; on the end of a message pad and return the digest
  function automatic bit hash_absorb(input logic [7:0] data, input bit present,
                                     input bit last, output digest_t dig);
    int n;
    dig = '0;
    if (present) begin
      msg_block[block_fill] = data;
      msg_bits   += 64'd8;
      block_fill = (block_fill + 1) % 64;
      if (block_fill == 0) hash_compress();
    end
    if (!last) return 1'b0;
    n = block_fill;
    msg_block[n] = PAD_BYTE;
    for (int i = n + 1; i < 64; i++) msg_block[i] = 8'h00;
    // No room for the length: finish this block and pad a fresh one
    if (n >= LEN_OFFSET) begin
      hash_compress();
      for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;
    end
    for (int i = 0; i < 8; i++) msg_block[LEN_OFFSET + i] = msg_bits[63 - 8*i -: 8];
    hash_compress();
    dig = {hash_state[0], hash_state[1], hash_state[2], hash_state[3],
           hash_state[4], hash_state[5], hash_state[6], hash_state[7]};
    hash_restart();
    return 1'b1;
  endfunction

  // Offer one item at the falling edge, hold it until the transfer happens
  task automatic push_item(input logic [7:0] data, input bit present, input bit last,
                           input bit known, input digest_t want);
    int      gap;
    digest_t dig;
    gap = 0;
    if (!calm && $urandom_range(0, 99) < src_idle_pct) gap = $urandom_range(1, 12);
    @(negedge clk);
    if (gap > 0) begin
      msg_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    msg_ch.valid        <= 1'b1;
    msg_ch.data_byte    <= data;
    msg_ch.byte_present <= present;
    msg_ch.last_item    <= last;
    do @(posedge clk); while (!msg_ch.ready);
    items_sent++;
    if (items_sent % 64 == 0) begin
      case ($urandom_range(0, 2))
        0:       src_idle_pct = 0;
        1:       src_idle_pct = 10;
        default: src_idle_pct = 35;
      endcase
    end
    if (hash_absorb(data, present, last, dig)) begin
      pending_digests.push_back(known ? want : dig);
    end
  endtask

  // Digest side: random stall bursts plus one long hold-off
  initial begin
    dig_ch.ready = 1'b0;
    sink_hold    = 0;
    snk_idle_pct = 15;
    forever begin
      @(negedge clk);
      if (cycle_count % 200 == 0) begin
        case ($urandom_range(0, 2))
          0:       snk_idle_pct = 0;
          1:       snk_idle_pct = 15;
          default: snk_idle_pct = 40;
        endcase
      end
      if (sink_hold > 0) begin
        sink_hold--;
      end else if (!long_hold_done && digests_seen >= 10) begin
        sink_hold      = LONG_HOLD;
        long_hold_done = 1'b1;
      end else if (!calm && $urandom_range(0, 99) < snk_idle_pct) begin
        sink_hold = $urandom_range(1, 12);
      end
      dig_ch.ready <= (sink_hold == 0) && !rst;
    end
  end

  // Check each digest transfer against the oldest pending digest
  always @(posedge clk) begin
    digest_t exp_dig;
    digest_t got_dig;
    string   field_name [4];
    field_name = '{"digest_high", "digest_upper_mid", "digest_lower_mid", "digest_low"};
    if (!rst && dig_ch.valid && dig_ch.ready) begin
      got_dig = {dig_ch.digest_high, dig_ch.digest_upper_mid,
                 dig_ch.digest_lower_mid, dig_ch.digest_low};
      digests_seen++;
      if (pending_digests.size() == 0) begin
        errors++;
        $display("%0t: unexpected digest, expected none, actual %h", $time, got_dig);
      end else begin
        exp_dig = pending_digests.pop_front();
        for (int i = 0; i < 4; i++) begin
          if (got_dig[255 - 64*i -: 64] !== exp_dig[255 - 64*i -: 64]) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field_name[i],
                     exp_dig[255 - 64*i -: 64], got_dig[255 - 64*i -: 64]);
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int         len;
    int         pattern;
    bit         end_on_byte;
    logic [7:0] b;
    rst                 = 1'b1;
    msg_ch.valid        = 1'b0;
    msg_ch.data_byte    = '0;
    msg_ch.byte_present = 1'b0;
    msg_ch.last_item    = 1'b0;
    errors              = 0;
    items_sent          = 0;
    digests_seen        = 0;
    cycle_count         = 0;
    src_idle_pct        = 10;
    long_hold_done      = 1'b0;
    calm                = 1'b0;
    hash_restart();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table
    for (int r = 0; r < DIR_ROWS; r++)
      push_item(DIRECTED[r].data, DIRECTED[r].present, DIRECTED[r].last,
                DIRECTED[r].known, DIRECTED[r].want);

    // Random messages: edge lengths and short random lengths, odd empty items
    while (items_sent < DIR_ROWS + RANDOM_ITEMS) begin
      calm = (items_sent > DIR_ROWS + RANDOM_ITEMS - CALM_ITEMS);
      if ($urandom_range(0, 3) == 0) len = EDGE_LENS[$urandom_range(0, 12)];
      else len = $urandom_range(0, 60);
      pattern     = $urandom_range(0, 7);
      end_on_byte = (len > 0) && $urandom_range(0, 1);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 11) == 0) push_item(8'($urandom), 1'b0, 1'b0, 1'b0, '0);
        case (pattern)
          0:       b = 8'h00;
          1:       b = 8'hff;
          default: b = 8'($urandom);
        endcase
        push_item(b, 1'b1, end_on_byte && (k == len - 1), 1'b0, '0);
      end
      if (!end_on_byte) push_item(8'($urandom), 1'b0, 1'b1, 1'b0, '0);
    end

    @(negedge clk);
    msg_ch.valid <= 1'b0;
    while (pending_digests.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+src
src/sbh_pkg.sv
src/sbh_if.sv
src/sha256_byte_stream_hasher.sv
src/sbh_checker.sv
tb/tb.sv
